// ===== rtl/ffpa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffpa_pkg
// shared types and codes for the first-fit partition allocator
// ----------------------------------------------------------------------------
package ffpa_pkg;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	localparam logic [1:0] STAT_LOADED  = 2'd0;
	localparam logic [1:0] STAT_GRANTED = 2'd1;
	localparam logic [1:0] STAT_NOFIT   = 2'd2;

	localparam int GRP_W = 16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic compare;
		logic scan;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic is_alloc;
		logic hit;
		logic last_grp;
		logic out_free;
	} stat_t;

endpackage

// ===== rtl/ffpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffpa_ctrl
// sequencer: capture, compare all partitions, allocate-only group scan, commit
// ----------------------------------------------------------------------------
module ffpa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  ffpa_pkg::stat_t st,
	output ffpa_pkg::cmd_t  cmd
);
	import ffpa_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_CMP;
			end
			ST_CMP: begin
				state_nxt = st.is_alloc ? ST_SCAN : ST_DONE;
			end
			ST_SCAN: begin
				if (st.hit || st.last_grp) state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (st.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			ST_CMP:  cmd.compare = 1'b1;
			ST_SCAN: cmd.scan    = 1'b1;
			ST_DONE: cmd.commit  = st.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== rtl/ffpa_dpath.sv =====
// ----------------------------------------------------------------------------
// ffpa_dpath
// partition lanes, fit vector, group priority pick, total and output register
// ----------------------------------------------------------------------------
module ffpa_dpath #(
	parameter int NUM_PARTITIONS = 16,
	parameter int SIZE_BITS      = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ffpa_pkg::cmd_t  cmd,
	output ffpa_pkg::stat_t st,
	input  logic            op,
	input  logic [3:0]      part_index,
	input  logic [15:0]     amount,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [1:0]      status,
	output logic [3:0]      chosen_index,
	output logic [15:0]     leftover,
	output logic [19:0]     total_free
);
	import ffpa_pkg::*;

	localparam int AW = (SIZE_BITS < 16) ? SIZE_BITS : 16;
	localparam int IW = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
	localparam int NG = (NUM_PARTITIONS + GRP_W - 1) / GRP_W;
	localparam int GW = (NG > 1) ? $clog2(NG) : 1;

	logic [SIZE_BITS-1:0]      size_q [NUM_PARTITIONS];
	logic [NUM_PARTITIONS-1:0] filled_q;
	logic [NUM_PARTITIONS-1:0] fit_q;
	logic [20:0]               total_q;

	logic                      op_q;
	logic [3:0]                idx_q;
	logic [SIZE_BITS-1:0]      amt_q;
	logic [GW-1:0]             grp_q;
	logic [IW-1:0]             pick_q;
	logic                      found_q;

	logic                      out_valid_q;
	logic [1:0]                status_q;
	logic [3:0]                chosen_q;
	logic [15:0]               left_q;
	logic [19:0]               tot_out_q;

	logic [NG*GRP_W-1:0]       fit_pad;
	logic [GRP_W-1:0]          grp_bits;
	logic [3:0]                grp_lo;
	logic                      ld_ok;
	logic [IW-1:0]             ld_sel;
	logic [IW-1:0]             rd_idx;
	logic [SIZE_BITS-1:0]      rd_size;
	logic [SIZE_BITS-1:0]      new_left;
	logic [20:0]               total_nxt;
	logic                      out_free;

	assign fit_pad  = (NG*GRP_W)'(fit_q);
	assign grp_bits = fit_pad[grp_q*GRP_W +: GRP_W];

	always_comb begin
		grp_lo = '0;
		for (int k = GRP_W - 1; k >= 0; k--) begin
			if (grp_bits[k]) grp_lo = k[3:0];
		end
	end

	assign ld_ok     = ({5'd0, idx_q} < 9'(NUM_PARTITIONS));
	assign ld_sel    = IW'(idx_q);
	assign rd_idx    = op_q ? pick_q : ld_sel;
	assign rd_size   = size_q[rd_idx];
	assign new_left  = op_q ? (rd_size - amt_q) : amt_q;
	assign total_nxt = op_q ? (total_q - 21'(amt_q))
	                        : (total_q - 21'(rd_size) + 21'(amt_q));
	assign out_free  = !out_valid_q || !out_stall;

	assign st.is_alloc = op_q;
	assign st.hit      = |grp_bits;
	assign st.last_grp = (grp_q == GW'(NG - 1));
	assign st.out_free = out_free;

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= op;
			idx_q <= part_index;
			amt_q <= SIZE_BITS'(amount[AW-1:0]);
		end
	end

	// compare and group scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_q   <= '0;
			grp_q   <= '0;
			pick_q  <= '0;
			found_q <= 1'b0;
		end else if (cmd.compare) begin
			for (int k = 0; k < NUM_PARTITIONS; k++) begin
				fit_q[k] <= !filled_q[k] && (amt_q <= size_q[k]);
			end
			grp_q   <= '0;
			found_q <= 1'b0;
		end else if (cmd.scan) begin
			if (|grp_bits) begin
				pick_q  <= IW'({grp_q, grp_lo});
				found_q <= 1'b1;
			end else if (grp_q != GW'(NG - 1)) begin
				grp_q <= grp_q + 1'b1;
			end
		end
	end

	// partition lanes and running total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_PARTITIONS; k++) size_q[k] <= '0;
			filled_q <= '0;
			total_q  <= '0;
		end else if (cmd.commit) begin
			if (!op_q && ld_ok) begin
				size_q[rd_idx]   <= new_left;
				filled_q[rd_idx] <= 1'b0;
				total_q          <= total_nxt;
			end else if (op_q && found_q) begin
				size_q[rd_idx]   <= new_left;
				filled_q[rd_idx] <= 1'b1;
				total_q          <= total_nxt;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (!op_q) begin
				status_q  <= STAT_LOADED;
				chosen_q  <= idx_q;
				left_q    <= ld_ok ? 16'(new_left) : 16'd0;
				tot_out_q <= ld_ok ? total_nxt[19:0] : total_q[19:0];
			end else if (found_q) begin
				status_q  <= STAT_GRANTED;
				chosen_q  <= 4'(pick_q);
				left_q    <= 16'(new_left);
				tot_out_q <= total_nxt[19:0];
			end else begin
				status_q  <= STAT_NOFIT;
				chosen_q  <= 4'd0;
				left_q    <= 16'd0;
				tot_out_q <= total_q[19:0];
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign chosen_index = chosen_q;
	assign leftover     = left_q;
	assign total_free   = tot_out_q;

endmodule

// ===== rtl/first_fit_partition_allocator_top.sv =====
// ----------------------------------------------------------------------------
// first_fit_partition_allocator_top
// fixed-partition first-fit allocator: load partition sizes, grant requests
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_stall  | op, part_index, amount
//  out     | out_valid / out_stall| status, chosen_index, leftover, total_free
//
//  one item at a time; a load goes from capture through compare to write-back
//  an allocate runs one compare of all partitions, then a priority scan of
//  16 fit bits per cycle, then write-back
//  input is taken again in the cycle after write-back
//  arst_n clears all sizes, filled flags and the total at once
//  a held result blocks the write-back of the next item until it is taken
// ----------------------------------------------------------------------------
module first_fit_partition_allocator_top #(
	parameter int NUM_PARTITIONS = 16,
	parameter int SIZE_BITS      = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [3:0]  part_index,
	input  logic [15:0] amount,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [3:0]  chosen_index,
	output logic [15:0] leftover,
	output logic [19:0] total_free
);
	import ffpa_pkg::*;

	cmd_t  cmd;
	stat_t st;

	ffpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	ffpa_dpath #(
		.NUM_PARTITIONS (NUM_PARTITIONS),
		.SIZE_BITS      (SIZE_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.op           (op),
		.part_index   (part_index),
		.amount       (amount),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.chosen_index (chosen_index),
		.leftover     (leftover),
		.total_free   (total_free)
	);

endmodule
